// ----- rtl/core/sns_pkg.sv -----
// shared types, constants and helpers for the spiking neuron step block
`timescale 1ns / 1ps
`default_nettype none

package sns_pkg;

    // fixed widths of the datapath
    localparam int WORD_W   = 32;
    localparam int ACC_W    = 64;
    localparam int MUL_A_W  = 35;
    localparam int MUL_B_W  = 20;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int BASE_W   = 35;
    localparam int SQHI_W   = 23;
    localparam int RATE_W   = 18;
    localparam int SENS_W   = 19;
    localparam int CFG_IDX_W = 3;

    // model constants: K_QUAD and K_CONST in q16.16, K_LIN a plain integer factor
    localparam logic signed [MUL_B_W-1:0] K_QUAD  = 20'sd2621;
    localparam logic signed [MUL_B_W-1:0] K_LIN   = 20'sd5;
    localparam logic signed [WORD_W-1:0]  K_CONST = 32'sd9175040;

    // reset values
    localparam logic signed [WORD_W-1:0]  V_RESET        = 32'shFFBF0000;
    localparam logic [RATE_W-1:0]         RATE_RESET     = 18'd1311;
    localparam logic signed [SENS_W-1:0]  SENS_RESET     = 19'sd13107;
    localparam logic signed [WORD_W-1:0]  JUMP_RESET     = 32'sd524288;
    localparam logic signed [WORD_W-1:0]  BIAS_RESET     = 32'sd0;
    localparam logic signed [WORD_W-1:0]  THRESH_RESET   = 32'sd1966080;
    localparam logic signed [WORD_W-1:0]  FLOOR_RESET    = 32'sh80000000;

    // saturation bounds in accumulator width
    localparam logic signed [ACC_W-1:0] SAT_HI = 64'sh000000007FFFFFFF;
    localparam logic signed [ACC_W-1:0] SAT_LO = 64'shFFFFFFFF80000000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE,
        CFG_SENS,
        CFG_RESET_V,
        CFG_JUMP,
        CFG_BIAS,
        CFG_THRESH,
        CFG_FLOOR,
        CFG_MODE
    } cfg_reg_t;

    // input and result transactions
    typedef struct packed {
        logic signed [WORD_W-1:0] synaptic_input;
        logic signed [WORD_W-1:0] next_current;
    } sns_in_t;

    typedef struct packed {
        logic                     spiked;
        logic signed [WORD_W-1:0] potential;
        logic signed [WORD_W-1:0] recovery;
    } sns_out_t;

    // multiplier operand selects
    typedef enum logic [2:0] {
        MA_X,
        MA_VOLD,
        MA_SQLO,
        MA_SQHI,
        MA_DIFF
    } mul_a_sel_t;

    typedef enum logic [2:0] {
        MB_XLO,
        MB_XHI,
        MB_FIVE,
        MB_KQUAD,
        MB_SENS,
        MB_RATE
    } mul_b_sel_t;

    // accumulator operand selects
    typedef enum logic [3:0] {
        OA_ZERO,
        OA_ACC,
        OA_ACC_Q16,
        OA_ACC_STEP,
        OA_ACC_HALF,
        OA_PROD_Q16,
        OA_PROD_QS,
        OA_KCONST,
        OA_UN
    } acc_a_sel_t;

    typedef enum logic [3:0] {
        OB_ZERO,
        OB_PROD,
        OB_PROD_S16,
        OB_PROD_S24,
        OB_CUR,
        OB_BIAS,
        OB_NEG_U,
        OB_U,
        OB_SYN,
        OB_X,
        OB_JUMP,
        OB_BASE
    } acc_b_sel_t;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_B0, S_B1, S_B2, S_B3,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8, S_F9, S_F10,
        S_R0, S_R1, S_R2, S_R3, S_R4, S_R5,
        S_DONE
    } sns_state_t;

    // control word from the sequencer to the datapath
    typedef struct packed {
        logic       ready;
        logic       commit;
        mul_a_sel_t mul_a;
        mul_b_sel_t mul_b;
        acc_a_sel_t acc_a;
        acc_b_sel_t acc_b;
        logic       acc_en;
        logic       base_ld;
        logic       sqhi_ld;
        logic       x_ld;
        logic       un_ld;
        logic       clamp;
    } sns_ctl_t;

    // sign extend a word to accumulator width
    function automatic logic signed [ACC_W-1:0] ext_word(input logic signed [WORD_W-1:0] w);
        ext_word = {{(ACC_W - WORD_W){w[WORD_W-1]}}, w};
    endfunction

    // clip an accumulator value to the signed word range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] x);
        logic signed [WORD_W-1:0] r;
        if (x > SAT_HI)
            r = SAT_HI[WORD_W-1:0];
        else if (x < SAT_LO)
            r = SAT_LO[WORD_W-1:0];
        else
            r = x[WORD_W-1:0];
        sat_word = r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sns_mul.sv -----
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none

module sns_mul (
    input  logic                                clk,
    input  logic signed [sns_pkg::MUL_A_W-1:0]  a,
    input  logic signed [sns_pkg::MUL_B_W-1:0]  b,
    output logic signed [sns_pkg::PROD_W-1:0]   p
);
    import sns_pkg::*;

    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;

    // full-width signed product
    assign p_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sns_ctrl.sv -----
// sequencer driving the shared multiplier and accumulator
`timescale 1ns / 1ps
`default_nettype none

module sns_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              mode,
    input  logic              out_free,
    output sns_pkg::sns_ctl_t ctl
);
    import sns_pkg::*;

    sns_state_t state_reg;
    sns_state_t state_next;
    logic       half_reg;
    logic       half_next;

    // state and half-step flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg  <= half_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        half_next  = half_reg;
        case (state_reg)
            S_IDLE:
            begin
                half_next = 1'b0;
                if (start)
                    state_next = S_B0;
            end
            S_B0:  state_next = S_B1;
            S_B1:  state_next = S_B2;
            S_B2:  state_next = S_B3;
            S_B3:  state_next = S_F0;
            S_F0:  state_next = S_F1;
            S_F1:  state_next = S_F2;
            S_F2:  state_next = S_F3;
            S_F3:  state_next = S_F4;
            S_F4:  state_next = S_F5;
            S_F5:  state_next = S_F6;
            S_F6:  state_next = S_F7;
            S_F7:  state_next = S_F8;
            S_F8:  state_next = S_F9;
            S_F9:  state_next = S_F10;
            S_F10:
            begin
                // second half-step reuses the same sequence
                if (!mode && !half_reg)
                begin
                    half_next  = 1'b1;
                    state_next = S_F0;
                end
                else
                begin
                    state_next = S_R0;
                end
            end
            S_R0:  state_next = S_R1;
            S_R1:  state_next = S_R2;
            S_R2:  state_next = S_R3;
            S_R3:  state_next = S_R4;
            S_R4:  state_next = S_R5;
            S_R5:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control word
    always_comb
    begin
        ctl         = '0;
        ctl.mul_a   = MA_X;
        ctl.mul_b   = MB_XLO;
        ctl.acc_a   = OA_ZERO;
        ctl.acc_b   = OB_ZERO;
        case (state_reg)
            S_IDLE: ctl.ready = 1'b1;
            // base term: constant - u + current + bias (+ synaptic in half-step mode)
            S_B0:
            begin
                ctl.acc_a  = OA_KCONST;
                ctl.acc_b  = OB_NEG_U;
                ctl.acc_en = 1'b1;
            end
            S_B1:
            begin
                ctl.acc_a  = OA_ACC;
                ctl.acc_b  = OB_CUR;
                ctl.acc_en = 1'b1;
            end
            S_B2:
            begin
                ctl.acc_a  = OA_ACC;
                ctl.acc_b  = OB_BIAS;
                ctl.acc_en = 1'b1;
            end
            S_B3:
            begin
                ctl.acc_a  = OA_ACC;
                ctl.acc_b  = mode ? OB_ZERO : OB_SYN;
                ctl.acc_en = 1'b1;
            end
            // v squared from two partial products
            S_F0:
            begin
                ctl.base_ld = !half_reg;
                ctl.mul_a   = MA_X;
                ctl.mul_b   = MB_XLO;
            end
            S_F1:
            begin
                ctl.mul_a  = MA_X;
                ctl.mul_b  = MB_XHI;
                ctl.acc_a  = OA_ZERO;
                ctl.acc_b  = OB_PROD;
                ctl.acc_en = 1'b1;
            end
            S_F2:
            begin
                ctl.acc_a  = OA_ACC;
                ctl.acc_b  = OB_PROD_S16;
                ctl.acc_en = 1'b1;
            end
            // quadratic coefficient, split in two partial products
            S_F3:
            begin
                ctl.mul_a   = MA_SQLO;
                ctl.mul_b   = MB_KQUAD;
                ctl.sqhi_ld = 1'b1;
            end
            S_F4:
            begin
                ctl.mul_a  = MA_SQHI;
                ctl.mul_b  = MB_KQUAD;
                ctl.acc_a  = OA_ZERO;
                ctl.acc_b  = OB_PROD;
                ctl.acc_en = 1'b1;
            end
            S_F5:
            begin
                ctl.mul_a  = MA_X;
                ctl.mul_b  = MB_FIVE;
                ctl.acc_a  = OA_ACC;
                ctl.acc_b  = OB_PROD_S24;
                ctl.acc_en = 1'b1;
            end
            S_F6:
            begin
                ctl.acc_a  = OA_ACC_Q16;
                ctl.acc_b  = OB_PROD;
                ctl.acc_en = 1'b1;
            end
            S_F7:
            begin
                ctl.acc_a  = OA_ACC;
                ctl.acc_b  = OB_BASE;
                ctl.acc_en = 1'b1;
            end
            // scale derivative by the step and add to v
            S_F8:
            begin
                ctl.acc_a  = mode ? OA_ACC_STEP : OA_ACC_HALF;
                ctl.acc_b  = OB_X;
                ctl.acc_en = 1'b1;
            end
            S_F9:
            begin
                ctl.acc_a  = OA_ACC;
                ctl.acc_b  = mode ? OB_SYN : OB_ZERO;
                ctl.acc_en = 1'b1;
            end
            S_F10: ctl.x_ld = 1'b1;
            // recovery update
            S_R0:
            begin
                ctl.mul_a = mode ? MA_VOLD : MA_X;
                ctl.mul_b = MB_SENS;
                ctl.clamp = 1'b1;
            end
            S_R1:
            begin
                ctl.acc_a  = OA_PROD_Q16;
                ctl.acc_b  = OB_NEG_U;
                ctl.acc_en = 1'b1;
            end
            S_R2:
            begin
                ctl.mul_a = MA_DIFF;
                ctl.mul_b = MB_RATE;
            end
            S_R3:
            begin
                ctl.acc_a  = OA_PROD_QS;
                ctl.acc_b  = OB_U;
                ctl.acc_en = 1'b1;
            end
            S_R4: ctl.un_ld = 1'b1;
            S_R5:
            begin
                ctl.acc_a  = OA_UN;
                ctl.acc_b  = OB_JUMP;
                ctl.acc_en = 1'b1;
            end
            S_DONE: ctl.commit = out_free;
            default: ctl.ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/spiking_neuron_step.sv -----
// quadratic spiking neuron tick on one shared multiplier and accumulator.
// The result is registered after acceptance, with Euler stepping or two half-steps;
// a new input is taken only once the previous result has been committed.
// The sequencer walks the single multiplier and the 64-bit accumulator through
// each derivative and the recovery update, and holds while the output slot is full.
// Reset (async, active low) loads the register defaults, v = -65.0, u = 0, I = 0.
`timescale 1ns / 1ps
`default_nettype none

module spiking_neuron_step #(
    parameter int STEP_SHIFT = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sns_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sns_pkg::WORD_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sns_pkg::sns_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sns_pkg::sns_out_t                   out_data
);
    import sns_pkg::*;

    // configuration registers
    logic [RATE_W-1:0]         rate_reg;
    logic signed [SENS_W-1:0]  sens_reg;
    logic signed [WORD_W-1:0]  c_reg;
    logic signed [WORD_W-1:0]  jump_reg;
    logic signed [WORD_W-1:0]  bias_reg;
    logic signed [WORD_W-1:0]  thr_reg;
    logic signed [WORD_W-1:0]  floor_reg;
    logic                      mode_reg;

    // neuron state
    logic signed [WORD_W-1:0]  v_reg;
    logic signed [WORD_W-1:0]  u_reg;
    logic signed [WORD_W-1:0]  cur_reg;
    logic signed [WORD_W-1:0]  v_next;
    logic signed [WORD_W-1:0]  u_next;

    // working registers
    logic signed [WORD_W-1:0]  x_reg;
    logic signed [WORD_W-1:0]  x_next;
    logic signed [WORD_W-1:0]  syn_reg;
    logic signed [WORD_W-1:0]  nxt_reg;
    logic signed [WORD_W-1:0]  un_reg;
    logic signed [BASE_W-1:0]  base_reg;
    logic [SQHI_W-1:0]         sqhi_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;

    // output slot
    logic                      out_valid_reg;
    logic                      out_valid_next;
    sns_out_t                  out_data_reg;
    sns_out_t                  out_data_next;

    // datapath wiring
    sns_ctl_t                  ctl;
    logic                      accept;
    logic                      out_free;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   op_a;
    logic signed [ACC_W-1:0]   op_b;
    logic signed [WORD_W-1:0]  acc_sat;
    logic                      spike_w;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = ctl.ready;

    sns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .mode     (mode_reg),
        .out_free (out_free),
        .ctl      (ctl)
    );

    // multiplier operand selection
    always_comb
    begin
        case (ctl.mul_a)
            MA_X:    mul_a = {{(MUL_A_W - WORD_W){x_reg[WORD_W-1]}}, x_reg};
            MA_VOLD: mul_a = {{(MUL_A_W - WORD_W){v_reg[WORD_W-1]}}, v_reg};
            MA_SQLO: mul_a = {11'd0, acc_reg[39:16]};
            MA_SQHI: mul_a = {{(MUL_A_W - SQHI_W){1'b0}}, sqhi_reg};
            MA_DIFF: mul_a = acc_reg[MUL_A_W-1:0];
            default: mul_a = '0;
        endcase
    end

    always_comb
    begin
        case (ctl.mul_b)
            MB_XLO:   mul_b = {4'd0, x_reg[15:0]};
            MB_XHI:   mul_b = {{4{x_reg[WORD_W-1]}}, x_reg[31:16]};
            MB_FIVE:  mul_b = K_LIN;
            MB_KQUAD: mul_b = K_QUAD;
            MB_SENS:  mul_b = {sens_reg[SENS_W-1], sens_reg};
            MB_RATE:  mul_b = {2'b00, rate_reg};
            default:  mul_b = '0;
        endcase
    end

    sns_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

    // accumulator operands
    always_comb
    begin
        case (ctl.acc_a)
            OA_ZERO:     op_a = '0;
            OA_ACC:      op_a = acc_reg;
            OA_ACC_Q16:  op_a = acc_reg >>> 16;
            OA_ACC_STEP: op_a = acc_reg >>> STEP_SHIFT;
            OA_ACC_HALF: op_a = acc_reg >>> (STEP_SHIFT + 1);
            OA_PROD_Q16: op_a = prod_ext >>> 16;
            OA_PROD_QS:  op_a = prod_ext >>> (16 + STEP_SHIFT);
            OA_KCONST:   op_a = ext_word(K_CONST);
            OA_UN:       op_a = ext_word(un_reg);
            default:     op_a = '0;
        endcase
    end

    always_comb
    begin
        case (ctl.acc_b)
            OB_ZERO:     op_b = '0;
            OB_PROD:     op_b = prod_ext;
            OB_PROD_S16: op_b = prod_ext <<< 16;
            OB_PROD_S24: op_b = prod_ext <<< 24;
            OB_CUR:      op_b = ext_word(cur_reg);
            OB_BIAS:     op_b = ext_word(bias_reg);
            OB_NEG_U:    op_b = -ext_word(u_reg);
            OB_U:        op_b = ext_word(u_reg);
            OB_SYN:      op_b = ext_word(syn_reg);
            OB_X:        op_b = ext_word(x_reg);
            OB_JUMP:     op_b = ext_word(jump_reg);
            OB_BASE:     op_b = {{(ACC_W - BASE_W){base_reg[BASE_W-1]}}, base_reg};
            default:     op_b = '0;
        endcase
    end

    assign acc_next = op_a + op_b;
    assign acc_sat  = sat_word(acc_reg);

    // working potential: load, saturate result, apply floor
    always_comb
    begin
        x_next = x_reg;
        if (accept)
            x_next = v_reg;
        else if (ctl.x_ld)
            x_next = acc_sat;
        else if (ctl.clamp && (x_reg < floor_reg))
            x_next = floor_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.acc_en)
            acc_reg <= acc_next;
        if (accept)
        begin
            syn_reg <= in_data.synaptic_input;
            nxt_reg <= in_data.next_current;
        end
        if (ctl.base_ld)
            base_reg <= acc_reg[BASE_W-1:0];
        if (ctl.sqhi_ld)
            sqhi_reg <= acc_reg[62:40];
        if (ctl.un_ld)
            un_reg <= acc_sat;
        x_reg <= x_next;
    end

    // threshold test and state commit
    assign spike_w = (x_reg >= thr_reg);

    always_comb
    begin
        v_next = spike_w ? c_reg : x_reg;
        u_next = spike_w ? acc_sat : un_reg;
        out_data_next.spiked    = spike_w;
        out_data_next.potential = v_next;
        out_data_next.recovery  = u_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= V_RESET;
            u_reg   <= '0;
            cur_reg <= '0;
        end
        else if (ctl.commit)
        begin
            v_reg   <= v_next;
            u_reg   <= u_next;
            cur_reg <= nxt_reg;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RATE_RESET;
            sens_reg  <= SENS_RESET;
            c_reg     <= V_RESET;
            jump_reg  <= JUMP_RESET;
            bias_reg  <= BIAS_RESET;
            thr_reg   <= THRESH_RESET;
            floor_reg <= FLOOR_RESET;
            mode_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_RATE:    rate_reg  <= cfg_data[RATE_W-1:0];
                CFG_SENS:    sens_reg  <= cfg_data[SENS_W-1:0];
                CFG_RESET_V: c_reg     <= cfg_data;
                CFG_JUMP:    jump_reg  <= cfg_data;
                CFG_BIAS:    bias_reg  <= cfg_data;
                CFG_THRESH:  thr_reg   <= cfg_data;
                CFG_FLOOR:   floor_reg <= cfg_data;
                CFG_MODE:    mode_reg  <= cfg_data[0];
                default:     mode_reg  <= mode_reg;
            endcase
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // commit only into a free output slot
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (!out_valid_reg || out_ready))
        else $error("result committed over an untaken transaction");

    // a committed result is presented next cycle
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> out_valid_reg)
        else $error("committed result not presented");

    // a spike always reports the reset potential
    a_spike_reset: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit && spike_w |=> out_data_reg.spiked
                                  && (out_data_reg.potential == $past(c_reg)))
        else $error("spike without reset potential");

    // without a spike the potential lies between floor and threshold
    a_no_spike_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit && !spike_w |=> (out_data_reg.potential >= $past(floor_reg))
                                   && (out_data_reg.potential < $past(thr_reg)))
        else $error("potential outside floor and threshold");

    // busy after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input taken while a tick is in progress");

endmodule

`default_nettype wire
